// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL of the page frame replacement unit.
// Each macro compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge outside of reset.
`define PFR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pfr assertion failed");

// Check that an expression is never true outside of reset.
`define PFR_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("pfr forbidden condition seen");

`else

`define PFR_ASSERT(label, clk, rst, prop)

`define PFR_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== src/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared constants, register indexes and controller/datapath types of the
// page frame replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

   // Table geometry
   localparam int FRAMES      = 8;
   localparam int PAGE_BITS   = 16;
   localparam int FRAME_IDX_W = $clog2(FRAMES);
   localparam int FCNT_W      = $clog2(FRAMES + 1);
   localparam int STAMP_W     = 32;
   localparam int FAULT_W     = 32;

   // Configuration port
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 4;
   localparam int CSR_FRAMES_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY        = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 1'd1;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } pfr_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic start;   // latch the request, arm the scan
      logic scan;    // examine the frame at the scan index
      logic commit;  // update the table and load the result
   } pfr_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic match;   // frame under scan holds the requested page
      logic last;    // frame under scan is the last one in use
   } pfr_sts_type;

endpackage

`default_nettype wire

// ===== src/page_frame_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// page_frame_replacement_unit
// FIFO / LRU page frame replacement table: one page reference in, one
// hit/fill/evict report out.
//
//   channel  ports              direction  carries
//   req      req_valid/ready    in         page
//   rsp      rsp_valid/ready    out        hit, frame_index, evicted,
//                                          evicted_page, fault_count
//   csr      csr_wr_en          in         policy, frames_in_use
//
// An item is accepted, then the frame table is scanned one entry per cycle
// over the n frames in use (1 to 8), a hit stopping the scan early, and then
// the table is updated and the result loaded.
// Reset is synchronous and clears the frame table valid bits and stamps.
// A new item is taken while the previous result waits in the output
// register; commit holds while that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_replacement_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pfr_pkg::PAGE_BITS-1:0]   req_page,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic [pfr_pkg::FRAME_IDX_W-1:0] rsp_frame_index,
   output logic                            rsp_evicted,
   output logic [pfr_pkg::PAGE_BITS-1:0]   rsp_evicted_page,
   output logic [pfr_pkg::FAULT_W-1:0]     rsp_fault_count,
   input  logic                            csr_wr_en,
   input  logic [pfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pfr_pkg::*;

   pfr_cmd_type cmd;
   pfr_sts_type sts;

   // Sequencer
   pfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Frame table and result path
   pfr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_page         (req_page),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_count  (rsp_fault_count)
   );

endmodule

`default_nettype wire

// ===== src/pfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfr_ctrl
// Sequencer of the page frame replacement unit: takes one item, walks the
// frame scan and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pfr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pfr_pkg::pfr_cmd_type cmd,
   input  pfr_pkg::pfr_sts_type sts
);
   import pfr_pkg::*;

   pfr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // State and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.match || sts.last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on commit, drop once the item is taken
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   `PFR_ASSERT(a_start_to_scan, clock, reset, cmd.start |=> (state_ff == ST_SCAN))
   `PFR_ASSERT(a_scan_ends, clock, reset,
      (cmd.scan && (sts.match || sts.last)) |=> (state_ff == ST_COMMIT))
   `PFR_ASSERT(a_commit_shows, clock, reset, cmd.commit |=> rsp_valid_ff)
   `PFR_ASSERT_NEVER(a_no_overwrite, clock, reset,
      cmd.commit && rsp_valid_ff && !rsp_ready)

endmodule

`default_nettype wire

// ===== src/pfr_datapath.sv =====
// ----------------------------------------------------------------------------
// pfr_datapath
// Frame table, configuration registers, one-frame-per-cycle scan and the
// result register of the page frame replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  pfr_pkg::pfr_cmd_type                cmd,
   output pfr_pkg::pfr_sts_type                sts,
   input  logic                                csr_wr_en,
   input  logic [pfr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [pfr_pkg::PAGE_BITS-1:0]       req_page,
   output logic                                rsp_hit,
   output logic [pfr_pkg::FRAME_IDX_W-1:0]     rsp_frame_index,
   output logic                                rsp_evicted,
   output logic [pfr_pkg::PAGE_BITS-1:0]       rsp_evicted_page,
   output logic [pfr_pkg::FAULT_W-1:0]         rsp_fault_count
);
   import pfr_pkg::*;

   // Configuration
   logic                    policy_ff, policy_in;
   logic [CSR_FRAMES_W-1:0] frames_cfg_ff, frames_cfg_in;
   logic [FCNT_W-1:0]       n_act;

   // Frame table
   logic                 valid_ff [FRAMES];
   logic                 valid_in [FRAMES];
   logic [PAGE_BITS-1:0] fpage_ff [FRAMES];
   logic [STAMP_W-1:0]   stamp_ff [FRAMES];
   logic [STAMP_W-1:0]   stamp_in [FRAMES];
   logic                 fpage_we;

   // Global state
   logic [STAMP_W-1:0]     clock_ff, clock_in;
   logic [FRAME_IDX_W-1:0] fifo_ptr_ff, fifo_ptr_in;
   logic [FAULT_W-1:0]     faults_ff, faults_in;

   // Per-item scan state
   logic [PAGE_BITS-1:0]   page_ff, page_in;
   logic [FCNT_W-1:0]      n_ff, n_in;
   logic                   lru_ff, lru_in;
   logic [FRAME_IDX_W-1:0] scan_ff, scan_in;
   logic                   found_ff, found_in;
   logic [FRAME_IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic                   empty_ff, empty_in;
   logic [FRAME_IDX_W-1:0] free_frame_ff, free_frame_in;
   logic [STAMP_W-1:0]     best_stamp_ff, best_stamp_in;
   logic [FRAME_IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [PAGE_BITS-1:0]   best_page_ff, best_page_in;
   logic [FRAME_IDX_W-1:0] fifo_vict_ff, fifo_vict_in;
   logic [PAGE_BITS-1:0]   fifo_page_ff, fifo_page_in;

   // Result register
   logic                   hit_ff, hit_in;
   logic [FRAME_IDX_W-1:0] fidx_ff, fidx_in;
   logic                   ev_ff, ev_in;
   logic [PAGE_BITS-1:0]   evpage_ff, evpage_in;
   logic [FAULT_W-1:0]     fcount_ff, fcount_in;

   // Entry under scan and commit decision
   logic                   cur_valid;
   logic [PAGE_BITS-1:0]   cur_page;
   logic [STAMP_W-1:0]     cur_stamp;
   logic [FRAME_IDX_W-1:0] tgt;
   logic [FCNT_W-1:0]      tgt_next;

   // Clamp the frame count to 1..FRAMES
   always_comb begin
      if (frames_cfg_ff == '0) begin
         n_act = FCNT_W'(1);
      end else if (32'(frames_cfg_ff) > 32'(FRAMES)) begin
         n_act = FCNT_W'(FRAMES);
      end else begin
         n_act = FCNT_W'(frames_cfg_ff);
      end
   end

   // Read the frame at the scan index
   assign cur_valid = valid_ff[scan_ff];
   assign cur_page  = fpage_ff[scan_ff];
   assign cur_stamp = stamp_ff[scan_ff];

   assign sts.match = cur_valid && (cur_page == page_ff);
   assign sts.last  = (FCNT_W'(scan_ff) + FCNT_W'(1)) == n_ff;

   // Victim or fill target at commit
   always_comb begin
      if (found_ff) begin
         tgt = hit_idx_ff;
      end else if (empty_ff) begin
         tgt = free_frame_ff;
      end else if (lru_ff) begin
         tgt = best_idx_ff;
      end else begin
         tgt = fifo_vict_ff;
      end
   end
   assign tgt_next = FCNT_W'(tgt) + FCNT_W'(1);

   // Next values
   always_comb begin
      policy_in     = policy_ff;
      frames_cfg_in = frames_cfg_ff;
      valid_in      = valid_ff;
      stamp_in      = stamp_ff;
      fpage_we      = 1'b0;
      clock_in      = clock_ff;
      fifo_ptr_in   = fifo_ptr_ff;
      faults_in     = faults_ff;
      page_in       = page_ff;
      n_in          = n_ff;
      lru_in        = lru_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      empty_in      = empty_ff;
      free_frame_in = free_frame_ff;
      best_stamp_in = best_stamp_ff;
      best_idx_in   = best_idx_ff;
      best_page_in  = best_page_ff;
      fifo_vict_in  = fifo_vict_ff;
      fifo_page_in  = fifo_page_ff;
      hit_in        = hit_ff;
      fidx_in       = fidx_ff;
      ev_in         = ev_ff;
      evpage_in     = evpage_ff;
      fcount_in     = fcount_ff;

      // Configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_POLICY:        policy_in     = csr_wdata[0];
            CSR_FRAMES_IN_USE: frames_cfg_in = csr_wdata[CSR_FRAMES_W-1:0];
            default:           ;
         endcase
      end

      // Latch the request and arm the scan
      if (cmd.start) begin
         page_in  = req_page;
         n_in     = n_act;
         lru_in   = (policy_ff == POLICY_LRU);
         clock_in = clock_ff + STAMP_W'(1);
         scan_in  = '0;
         found_in = 1'b0;
         empty_in = 1'b0;
         if (FCNT_W'(fifo_ptr_ff) < n_act) begin
            fifo_vict_in = fifo_ptr_ff;
         end else begin
            fifo_vict_in = '0;
         end
      end

      // Examine one frame
      if (cmd.scan) begin
         if (sts.match) begin
            found_in   = 1'b1;
            hit_idx_in = scan_ff;
         end else begin
            if (!cur_valid && !empty_ff) begin
               empty_in      = 1'b1;
               free_frame_in = scan_ff;
            end
            if ((scan_ff == '0) || (cur_stamp < best_stamp_ff)) begin
               best_stamp_in = cur_stamp;
               best_idx_in   = scan_ff;
               best_page_in  = cur_page;
            end
            if (scan_ff == fifo_vict_ff) begin
               fifo_page_in = cur_page;
            end
            scan_in = scan_ff + FRAME_IDX_W'(1);
         end
      end

      // Update the table and load the result
      if (cmd.commit) begin
         hit_in    = found_ff;
         fidx_in   = tgt;
         ev_in     = 1'b0;
         evpage_in = '0;
         if (lru_ff) begin
            stamp_in[tgt] = clock_ff;
         end
         if (!found_ff) begin
            valid_in[tgt] = 1'b1;
            fpage_we      = 1'b1;
            if (!empty_ff) begin
               ev_in = 1'b1;
               if (lru_ff) begin
                  evpage_in = best_page_ff;
               end else begin
                  evpage_in = fifo_page_ff;
                  if (tgt_next >= n_ff) begin
                     fifo_ptr_in = '0;
                  end else begin
                     fifo_ptr_in = tgt_next[FRAME_IDX_W-1:0];
                  end
               end
            end
            if (faults_ff != '1) begin
               faults_in = faults_ff + FAULT_W'(1);
            end
         end
         fcount_in = faults_in;
      end
   end

   // Control state and stamps
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POLICY_FIFO;
         frames_cfg_ff <= CSR_FRAMES_W'(FRAMES);
         clock_ff      <= '0;
         fifo_ptr_ff   <= '0;
         faults_ff     <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            valid_ff[i] <= 1'b0;
            stamp_ff[i] <= '0;
         end
      end else begin
         policy_ff     <= policy_in;
         frames_cfg_ff <= frames_cfg_in;
         clock_ff      <= clock_in;
         fifo_ptr_ff   <= fifo_ptr_in;
         faults_ff     <= faults_in;
         valid_ff      <= valid_in;
         stamp_ff      <= stamp_in;
      end
   end

   // Page numbers of the frames
   always_ff @(posedge clock) begin
      if (fpage_we) begin
         fpage_ff[tgt] <= page_ff;
      end
   end

   // Scan and result payload
   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      n_ff          <= n_in;
      lru_ff        <= lru_in;
      scan_ff       <= scan_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      empty_ff      <= empty_in;
      free_frame_ff <= free_frame_in;
      best_stamp_ff <= best_stamp_in;
      best_idx_ff   <= best_idx_in;
      best_page_ff  <= best_page_in;
      fifo_vict_ff  <= fifo_vict_in;
      fifo_page_ff  <= fifo_page_in;
      hit_ff        <= hit_in;
      fidx_ff       <= fidx_in;
      ev_ff         <= ev_in;
      evpage_ff     <= evpage_in;
      fcount_ff     <= fcount_in;
   end

   assign rsp_hit          = hit_ff;
   assign rsp_frame_index  = fidx_ff;
   assign rsp_evicted      = ev_ff;
   assign rsp_evicted_page = evpage_ff;
   assign rsp_fault_count  = fcount_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_page_frame_replacement_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_frame_replacement_unit
// Self-checking bench for the FIFO / LRU page frame replacement unit.
// A directed table covers the extremes of the page number, frame fills, hits,
// FIFO round-robin and pointer wrap, LRU ties and the clamping of the frame
// count. Random phases follow over several policy and frame-count settings,
// with sender idling, receiver stalls and a long output hold-off. Every
// result is checked field by field against the typed row or an in-bench model.
// ----------------------------------------------------------------------------

module tb_page_frame_replacement_unit;
   import pfr_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 90;
   localparam int PRESSURE_ITEMS = 40;

   // one report of the unit, laid out as the result ports
   typedef struct packed {
      logic                   hit;
      logic [FRAME_IDX_W-1:0] frame;
      logic                   evicted;
      logic [PAGE_BITS-1:0]   evicted_page;
      logic [FAULT_W-1:0]     fault_count;
   } frame_result_type;

   typedef enum logic [1:0] {
      ROW_CONFIG,
      ROW_PAGE,
      ROW_CHECKED
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic                 policy;
      logic [3:0]           frames;
      logic [PAGE_BITS-1:0] page;
      frame_result_type     want;
   } stim_row_type;

   // DUT ports
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [PAGE_BITS-1:0]   req_page  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_hit;
   logic [FRAME_IDX_W-1:0] rsp_frame_index;
   logic                   rsp_evicted;
   logic [PAGE_BITS-1:0]   rsp_evicted_page;
   logic [FAULT_W-1:0]     rsp_fault_count;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_POLICY;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // frame table as the bench expects it
   logic                 tbl_valid [FRAMES];
   logic [PAGE_BITS-1:0] tbl_page  [FRAMES];
   logic [STAMP_W-1:0]   tbl_stamp [FRAMES];
   logic [STAMP_W-1:0]   tbl_clock  = '0;
   int                   tbl_fifo_next = 0;
   logic [FAULT_W-1:0]   tbl_faults = '0;
   logic                 cfg_policy = POLICY_FIFO;
   logic [3:0]           cfg_frames = 4'd8;

   frame_result_type expected_results [$];
   stim_row_type     dir_table [$];

   // traffic shaping
   int   req_idle_pct  = 0;
   int   rsp_stall_pct = 0;
   logic holdoff_req   = 1'b0;
   logic holdoff_ack   = 1'b0;
   int   holdoff_left  = 0;

   // bookkeeping
   int mismatch_count = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int hits_seen      = 0;
   int evictions_seen = 0;
   int cycle_count    = 0;

   page_frame_replacement_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_page         (req_page),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_count  (rsp_fault_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Look up one page in the expected table, update it and return the report.
   function automatic frame_result_type predict_lookup(input logic [PAGE_BITS-1:0] page);
      frame_result_type   r;
      int                 n;
      int                 idx;
      int                 free_frame;
      logic               found;
      logic               have_empty;
      logic [STAMP_W-1:0] oldest;
      r          = '0;
      found      = 1'b0;
      have_empty = 1'b0;
      idx        = 0;
      free_frame = 0;
      // clamp the frame count to 1..FRAMES
      n = int'(cfg_frames);
      if (n < 1) n = 1;
      if (n > FRAMES) n = FRAMES;
      tbl_clock = tbl_clock + 1'b1;
      // first matching frame, else remember the lowest empty one
      for (int i = 0; i < n; i++) begin
         if (!found) begin
            if (tbl_valid[i] && tbl_page[i] == page) begin
               found = 1'b1;
               idx   = i;
            end else if (!tbl_valid[i] && !have_empty) begin
               have_empty = 1'b1;
               free_frame = i;
            end
         end
      end
      if (found) begin
         if (cfg_policy == POLICY_LRU) tbl_stamp[idx] = tbl_clock;
      end else begin
         if (have_empty) begin
            idx = free_frame;
         end else if (cfg_policy == POLICY_LRU) begin
            // oldest stamp, ties to the lowest frame
            oldest = tbl_stamp[0];
            idx    = 0;
            for (int i = 1; i < n; i++) begin
               if (tbl_stamp[i] < oldest) begin
                  oldest = tbl_stamp[i];
                  idx    = i;
               end
            end
            r.evicted = 1'b1;
         end else begin
            // round-robin victim; a stale pointer falls back to frame 0
            idx           = (tbl_fifo_next < n) ? tbl_fifo_next : 0;
            tbl_fifo_next = (idx + 1 >= n) ? 0 : idx + 1;
            r.evicted     = 1'b1;
         end
         if (r.evicted) r.evicted_page = tbl_page[idx];
         tbl_valid[idx] = 1'b1;
         tbl_page[idx]  = page;
         if (cfg_policy == POLICY_LRU) tbl_stamp[idx] = tbl_clock;
         if (tbl_faults != '1) tbl_faults = tbl_faults + 1'b1;
      end
      r.hit         = found;
      r.frame       = FRAME_IDX_W'(idx);
      r.fault_count = tbl_faults;
      return r;
   endfunction

   // Table builders for the directed part.
   function automatic void config_row(input logic pol, input logic [3:0] fr);
      stim_row_type r;
      r         = '0;
      r.kind    = ROW_CONFIG;
      r.policy  = pol;
      r.frames  = fr;
      dir_table = {dir_table, r};
   endfunction

   function automatic void page_row(input logic [PAGE_BITS-1:0] pg);
      stim_row_type r;
      r         = '0;
      r.kind    = ROW_PAGE;
      r.page    = pg;
      dir_table = {dir_table, r};
   endfunction

   function automatic void checked_row(input logic [PAGE_BITS-1:0] pg, input logic h,
                                       input logic [FRAME_IDX_W-1:0] f, input logic ev,
                                       input logic [PAGE_BITS-1:0] evp,
                                       input logic [FAULT_W-1:0] fc);
      stim_row_type r;
      r                   = '0;
      r.kind              = ROW_CHECKED;
      r.page              = pg;
      r.want.hit          = h;
      r.want.frame        = f;
      r.want.evicted      = ev;
      r.want.evicted_page = evp;
      r.want.fault_count  = fc;
      dir_table           = {dir_table, r};
   endfunction

   // Page from a small working set most of the time, else anywhere.
   function automatic logic [PAGE_BITS-1:0] pick_page(input logic [PAGE_BITS-1:0] base,
                                                      input int span);
      if ($urandom_range(99) < 75) return base + PAGE_BITS'($urandom_range(0, span - 1));
      return PAGE_BITS'($urandom);
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Offer one item, hold it until taken, then queue its expected report.
   task automatic send_page(input logic [PAGE_BITS-1:0] pg, input logic use_typed,
                            input frame_result_type typed);
      frame_result_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page  <= pg;
      do @(posedge clock); while (!req_ready);
      predicted        = predict_lookup(pg);
      expected_results = {expected_results, (use_typed ? typed : predicted)};
      items_sent++;
   endtask

   // Drop valid and wait until every queued report has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic write_config(input logic pol, input logic [3:0] fr);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_POLICY;
      csr_wdata <= CSR_DATA_W'(pol);
      @(posedge clock);
      csr_index <= CSR_FRAMES_IN_USE;
      csr_wdata <= fr;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      cfg_policy = pol;
      cfg_frames = fr;
   endtask

   // Drive rsp_ready: random stalls, or a long hold-off when requested.
   always @(posedge clock) begin
      if (holdoff_req != holdoff_ack) begin
         holdoff_ack  <= holdoff_req;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare each accepted report with the oldest expectation.
   always @(posedge clock) begin : check_reports
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: report with no item outstanding, frame %0d fault count %0d",
                     $time, rsp_frame_index, rsp_fault_count);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_hit));
            check_field("frame_index", 32'(want.frame), 32'(rsp_frame_index));
            check_field("evicted", 32'(want.evicted), 32'(rsp_evicted));
            check_field("evicted_page", 32'(want.evicted_page), 32'(rsp_evicted_page));
            check_field("fault_count", want.fault_count, rsp_fault_count);
            results_seen++;
            if (rsp_hit) hits_seen++;
            if (rsp_evicted) evictions_seen++;
         end
      end
   end

   // Stop a hung run.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d reports outstanding",
               cycle_count, expected_results.size());
      $display("page_frame_replacement_unit test failed");
      $finish;
   end

   initial begin : stimulus
      logic [PAGE_BITS-1:0] ws_base;
      logic                 pol;
      logic [3:0]           fr;
      int                   n_eff;
      int                   span;

      for (int i = 0; i < FRAMES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_page[i]  = '0;
         tbl_stamp[i] = '0;
      end

      // after reset: FIFO over 8 frames; fill with the page extremes, then hit
      checked_row(16'h0000, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd1);
      checked_row(16'hFFFF, 1'b0, 3'd1, 1'b0, 16'h0000, 32'd2);
      checked_row(16'h0000, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd2);
      checked_row(16'hFFFF, 1'b1, 3'd1, 1'b0, 16'h0000, 32'd2);
      // two frames: round-robin evictions and pointer wrap
      config_row(POLICY_FIFO, 4'd2);
      checked_row(16'hAAAA, 1'b0, 3'd0, 1'b1, 16'h0000, 32'd3);
      checked_row(16'h5555, 1'b0, 3'd1, 1'b1, 16'hFFFF, 32'd4);
      checked_row(16'hAAAA, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd4);
      checked_row(16'h1234, 1'b0, 3'd0, 1'b1, 16'hAAAA, 32'd5);
      // zero frames acts as one; pointer past the count falls back to frame 0
      config_row(POLICY_FIFO, 4'd0);
      checked_row(16'h8001, 1'b0, 3'd0, 1'b1, 16'h1234, 32'd6);
      // LRU with equal stamps left by FIFO: lowest frame loses the tie
      config_row(POLICY_LRU, 4'd2);
      page_row(16'h9999);
      // count above the table acts as 8; hidden frames kept their pages
      config_row(POLICY_LRU, 4'd15);
      page_row(16'h5555);
      page_row(16'h0100);
      page_row(16'h0101);
      page_row(16'h0102);
      page_row(16'h0103);
      page_row(16'h0104);
      page_row(16'h0105);
      page_row(16'h7FFE);
      page_row(16'h0100);
      page_row(16'h0200);
      // switch policy with the table full
      config_row(POLICY_FIFO, 4'd8);
      page_row(16'h0300);
      page_row(16'h0100);
      config_row(POLICY_LRU, 4'd1);
      page_row(16'h0300);
      page_row(16'h4000);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (dir_table[r]) begin
         case (dir_table[r].kind)
            ROW_CONFIG:  write_config(dir_table[r].policy, dir_table[r].frames);
            ROW_CHECKED: send_page(dir_table[r].page, 1'b1, dir_table[r].want);
            default:     send_page(dir_table[r].page, 1'b0, '0);
         endcase
      end

      // random phases over policies, frame counts and traffic mixes
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       {pol, fr} = {POLICY_FIFO, 4'd8};
            1:       {pol, fr} = {POLICY_LRU, 4'd8};
            2:       {pol, fr} = {POLICY_FIFO, 4'd1};
            3:       {pol, fr} = {POLICY_LRU, 4'd3};
            4:       {pol, fr} = {POLICY_FIFO, 4'd5};
            5:       {pol, fr} = {POLICY_LRU, 4'd0};
            6:       {pol, fr} = {POLICY_FIFO, 4'd15};
            default: {pol, fr} = {POLICY_LRU, 4'd6};
         endcase
         write_config(pol, fr);
         n_eff   = (fr == 0) ? 1 : ((fr > FRAMES) ? FRAMES : fr);
         span    = n_eff + $urandom_range(0, 3);
         ws_base = PAGE_BITS'($urandom);

         // hold the output off while items keep coming, so the input backs up
         if (phase == 4) begin
            req_idle_pct = 0;
            holdoff_req <= ~holdoff_req;
            repeat (PRESSURE_ITEMS) send_page(pick_page(ws_base, span), 1'b0, '0);
         end

         case (phase % 4)
            0:       begin req_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1:       begin req_idle_pct = 70; rsp_stall_pct <= 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct <= 70; end
            default: begin req_idle_pct = 29; rsp_stall_pct <= 29; end
         endcase

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // pause the sender until everything outstanding has returned
            if (phase == 3 && k == PHASE_ITEMS / 2) drain_results();
            // move the working set now and then to force evictions
            if (k % 30 == 29) ws_base = PAGE_BITS'($urandom);
            send_page(pick_page(ws_base, span), 1'b0, '0);
         end
      end

      drain_results();
      repeat (2 * FRAMES + 4) @(posedge clock);

      $display("Checked %0d reports for %0d page references: %0d hits, %0d evictions.",
               results_seen, items_sent, hits_seen, evictions_seen);
      $display("Covered FIFO and LRU, frame counts 0 to 15, idle and stall mixes, long hold-off.");
      if (mismatch_count == 0) begin
         $display("page_frame_replacement_unit test passed");
      end else begin
         $display("page_frame_replacement_unit test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/pfr_pkg.sv
src/pfr_ctrl.sv
src/pfr_datapath.sv
src/page_frame_replacement_unit.sv
tb/sv/tb_page_frame_replacement_unit.sv
